### src/p1305_pkg.sv
package p1305_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int MSG_W       = 8 * BLOCK_BYTES + 1;
    localparam int ACC_W       = 130;
    localparam int LIMB_W      = 26;
    localparam int LIMBS       = 5;
    localparam int MUL_STEPS   = LIMBS;
    localparam int FOLD_PASSES = 2;
    localparam int POLY_C      = 5;

    // prime 2^130 - 5
    localparam logic [ACC_W-1:0] P_MOD = {ACC_W{1'b1}} - ACC_W'(POLY_C - 1);

    localparam logic [127:0] CLAMP_MASK = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic             absorb;
        logic             last;
        logic [MSG_W-1:0] msg;
    } item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_FOLD,
        BK_SUM,
        BK_FINAL,
        BK_TAG
    } bk_state_t;

    typedef enum logic [1:0] {
        REG_KEY_R_LOW,
        REG_KEY_R_HIGH,
        REG_KEY_S_LOW,
        REG_KEY_S_HIGH
    } reg_idx_t;

endpackage

### src/p1305_front.sv
module p1305_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [63:0]         block_low,
    input  logic [63:0]         block_high,
    input  logic [4:0]          block_len,
    input  logic                last_block,
    output logic                push_valid,
    output p1305_pkg::item_t    push_item,
    input  logic                push_ready
);

    logic               st_valid_reg;
    logic               st_valid_next;
    p1305_pkg::item_t   st_item_reg;
    p1305_pkg::item_t   st_item_next;
    p1305_pkg::item_t   cls_item;
    logic [4:0]         len;
    logic [127:0]       data;
    logic               in_fire;

    assign in_ready   = !st_valid_reg || push_ready;
    assign in_fire    = in_valid && in_ready;
    assign push_valid = st_valid_reg;
    assign push_item  = st_item_reg;

    assign len  = (block_len > 5'(p1305_pkg::BLOCK_BYTES)) ?
                  5'(p1305_pkg::BLOCK_BYTES) : block_len;
    assign data = {block_high, block_low};

    // keep the valid bytes and set the pad bit right after the last one
    always_comb
    begin
        cls_item.msg = '0;
        for (int k = 0; k < p1305_pkg::BLOCK_BYTES; k++)
        begin
            if (5'(k) < len)
            begin
                cls_item.msg[8*k +: 8] = data[8*k +: 8];
            end
            if (5'(k) == len)
            begin
                cls_item.msg[8*k] = 1'b1;
            end
        end
        if (len == 5'(p1305_pkg::BLOCK_BYTES))
        begin
            cls_item.msg[p1305_pkg::MSG_W-1] = 1'b1;
        end
        cls_item.absorb = (len != 5'd0);
        cls_item.last   = last_block;
    end

    always_comb
    begin
        st_valid_next = st_valid_reg;
        st_item_next  = st_item_reg;
        if (st_valid_reg && push_ready)
        begin
            st_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            st_valid_next = 1'b1;
            st_item_next  = cls_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_item_reg <= st_item_next;
    end

endmodule

### src/p1305_fifo.sv
module p1305_fifo #(
    parameter int DEPTH = p1305_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  p1305_pkg::item_t    push_item,
    output logic                push_ready,
    output logic                pop_valid,
    output p1305_pkg::item_t    pop_item,
    input  logic                pop_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    p1305_pkg::item_t   mem [DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW-1:0]      rd_ptr_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/p1305_back.sv
module p1305_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    input  p1305_pkg::item_t    pop_item,
    output logic                pop_ready,
    input  logic [127:0]        key_r,
    input  logic [127:0]        key_s,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         tag_low,
    output logic [63:0]         tag_high
);

    localparam int LW = p1305_pkg::LIMB_W;
    localparam int NL = p1305_pkg::LIMBS;
    localparam int HW = LW + 1;
    localparam int CFW = LW + 3;
    localparam int PW = HW + CFW;
    localparam int DW = PW + 3;
    localparam int AW = p1305_pkg::ACC_W;
    localparam int CRW = DW - LW;

    p1305_pkg::bk_state_t   state_reg;
    p1305_pkg::bk_state_t   state_next;
    logic [2:0]             cnt_reg;
    logic [2:0]             cnt_next;
    logic                   last_reg;
    logic                   last_next;
    logic [AW-1:0]          acc_reg;
    logic [AW-1:0]          acc_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [127:0]           tag_reg;
    logic [127:0]           tag_next;
    logic [HW-1:0]          h_reg [NL];
    logic [HW-1:0]          h_next [NL];
    logic [DW-1:0]          d_reg [NL];
    logic [DW-1:0]          d_next [NL];
    logic [AW-1:0]          w_reg;
    logic [AW-1:0]          w_next;

    logic [127:0]           r_clamp;
    logic [LW-1:0]          r_limb [NL];
    logic [CFW-1:0]         coef [2*NL-1];
    logic [3:0]             kidx [NL];
    logic [HW-1:0]          h_sel;
    logic [PW-1:0]          prod [NL];
    logic [DW-1:0]          d_mac [NL];
    logic [DW-1:0]          d_fold [NL];
    logic [CRW-1:0]         c4;
    logic [AW:0]            hsum;
    logic [AW:0]            vsum;
    logic [AW-1:0]          w_sum;
    logic [AW:0]            t_red;
    logic                   out_free;

    assign out_valid = out_valid_reg;
    assign tag_low   = tag_reg[63:0];
    assign tag_high  = tag_reg[127:64];
    assign out_free  = !out_valid_reg || out_ready;

    assign r_clamp = key_r & p1305_pkg::CLAMP_MASK;

    // r in 26-bit limbs; the wrapped coefficients carry the factor 5 of the fold
    always_comb
    begin
        for (int j = 0; j < NL - 1; j++)
        begin
            r_limb[j] = r_clamp[LW*j +: LW];
        end
        r_limb[NL-1] = LW'(r_clamp[127:LW*(NL-1)]);
        for (int k = 0; k < NL - 1; k++)
        begin
            coef[k] = ({3'b000, r_limb[k+1]} << 2) + {3'b000, r_limb[k+1]};
        end
        for (int k = NL - 1; k < 2*NL - 1; k++)
        begin
            coef[k] = {3'b000, r_limb[k-NL+1]};
        end
    end

    // one limb of h against all of r per cycle
    assign h_sel = h_reg[cnt_reg];

    always_comb
    begin
        for (int j = 0; j < NL; j++)
        begin
            kidx[j]  = 4'(j) + 4'(NL - 1) - {1'b0, cnt_reg};
            prod[j]  = h_sel * coef[kidx[j]];
            d_mac[j] = d_reg[j] + DW'(prod[j]);
        end
    end

    // carry pass, limbs handled side by side
    assign c4 = d_reg[NL-1][DW-1:LW];

    always_comb
    begin
        d_fold[0] = DW'(d_reg[0][LW-1:0]) + DW'({c4, 2'b00}) + DW'(c4);
        for (int j = 1; j < NL; j++)
        begin
            d_fold[j] = DW'(d_reg[j][LW-1:0]) + DW'(d_reg[j-1][DW-1:LW]);
        end
    end

    always_comb
    begin
        vsum = '0;
        for (int j = 0; j < NL; j++)
        begin
            vsum = vsum + ((AW+1)'(d_reg[j][LW:0]) << (LW*j));
        end
        w_sum = vsum[AW-1:0] + (vsum[AW] ? AW'(p1305_pkg::POLY_C) : '0);
    end

    // w >= p exactly when w + 5 reaches 2^130
    assign t_red = {1'b0, w_reg} + (AW+1)'(p1305_pkg::POLY_C);
    assign hsum  = {1'b0, acc_reg} + (AW+1)'(pop_item.msg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        tag_next       = tag_reg;
        h_next         = h_reg;
        d_next         = d_reg;
        w_next         = w_reg;
        pop_ready      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            p1305_pkg::BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    last_next = pop_item.last;
                    cnt_next  = '0;
                    for (int j = 0; j < NL - 1; j++)
                    begin
                        h_next[j] = HW'(hsum[LW*j +: LW]);
                    end
                    h_next[NL-1] = hsum[AW:LW*(NL-1)];
                    for (int j = 0; j < NL; j++)
                    begin
                        d_next[j] = '0;
                    end
                    if (pop_item.absorb)
                    begin
                        state_next = p1305_pkg::BK_MUL;
                    end
                    else if (pop_item.last)
                    begin
                        state_next = p1305_pkg::BK_TAG;
                    end
                end
            end
            p1305_pkg::BK_MUL:
            begin
                d_next   = d_mac;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'(p1305_pkg::MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = p1305_pkg::BK_FOLD;
                end
            end
            p1305_pkg::BK_FOLD:
            begin
                d_next   = d_fold;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'(p1305_pkg::FOLD_PASSES - 1))
                begin
                    cnt_next   = '0;
                    state_next = p1305_pkg::BK_SUM;
                end
            end
            p1305_pkg::BK_SUM:
            begin
                w_next     = w_sum;
                state_next = p1305_pkg::BK_FINAL;
            end
            p1305_pkg::BK_FINAL:
            begin
                acc_next   = t_red[AW] ? t_red[AW-1:0] : w_reg;
                state_next = last_reg ? p1305_pkg::BK_TAG : p1305_pkg::BK_IDLE;
            end
            p1305_pkg::BK_TAG:
            begin
                if (out_free)
                begin
                    tag_next       = acc_reg[127:0] + key_s;
                    out_valid_next = 1'b1;
                    acc_next       = '0;
                    state_next     = p1305_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = p1305_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= p1305_pkg::BK_IDLE;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        h_reg   <= h_next;
        d_reg   <= d_next;
        w_reg   <= w_next;
    end

    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == p1305_pkg::BK_FINAL |=> acc_reg < p1305_pkg::P_MOD)
        else $error("accumulator not fully reduced");

    a_tag_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == p1305_pkg::BK_TAG && out_free)
        |=> (out_valid_reg && acc_reg == '0 && state_reg == p1305_pkg::BK_IDLE))
        else $error("tag transaction did not clear accumulator");

    a_mul_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == p1305_pkg::BK_MUL && cnt_reg == 3'(p1305_pkg::MUL_STEPS - 1))
        |=> state_reg == p1305_pkg::BK_FOLD)
        else $error("multiply sequence overran");

    a_out_from_tag: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == p1305_pkg::BK_TAG))
        else $error("result raised outside tag state");

endmodule

### src/poly1305_mac_accumulator.sv
// Poly1305 authenticator. Write the key halves r (clamped inside) and s over
// the register port, then stream 16-byte blocks; the block marked last yields
// the 128-bit tag and clears the accumulator for the next message. Blocks are
// accepted back to back, while there is room, into a front stage and a queue of
// QUEUE_DEPTH entries; the back end takes each non-empty block through a load,
// five steps of the 26-bit limb multiplier, two carry passes, one sum and one
// final subtract of 2^130-5, forming the tag on a last block once the output
// is free; an empty block skips the multiply. As it takes one block at a time,
// the five-step limb multiply with its reduction sets the sustained rate.
module poly1305_mac_accumulator #(
    parameter int QUEUE_DEPTH = p1305_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    input  logic [4:0]  block_len,
    input  logic        last_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] tag_low,
    output logic [63:0] tag_high
);

    logic [63:0]            key_r_low_reg;
    logic [63:0]            key_r_low_next;
    logic [63:0]            key_r_high_reg;
    logic [63:0]            key_r_high_next;
    logic [63:0]            key_s_low_reg;
    logic [63:0]            key_s_low_next;
    logic [63:0]            key_s_high_reg;
    logic [63:0]            key_s_high_next;
    p1305_pkg::reg_idx_t    reg_idx;
    logic                   wr_fire;

    logic                   push_valid;
    p1305_pkg::item_t       push_item;
    logic                   push_ready;
    logic                   pop_valid;
    p1305_pkg::item_t       pop_item;
    logic                   pop_ready;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite && pready;
    assign reg_idx = p1305_pkg::reg_idx_t'(paddr[4:3]);

    always_comb
    begin
        key_r_low_next  = key_r_low_reg;
        key_r_high_next = key_r_high_reg;
        key_s_low_next  = key_s_low_reg;
        key_s_high_next = key_s_high_reg;
        if (wr_fire)
        begin
            case (reg_idx)
                p1305_pkg::REG_KEY_R_LOW:  key_r_low_next  = pwdata;
                p1305_pkg::REG_KEY_R_HIGH: key_r_high_next = pwdata;
                p1305_pkg::REG_KEY_S_LOW:  key_s_low_next  = pwdata;
                p1305_pkg::REG_KEY_S_HIGH: key_s_high_next = pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            p1305_pkg::REG_KEY_R_LOW:  prdata = key_r_low_reg;
            p1305_pkg::REG_KEY_R_HIGH: prdata = key_r_high_reg;
            p1305_pkg::REG_KEY_S_LOW:  prdata = key_s_low_reg;
            p1305_pkg::REG_KEY_S_HIGH: prdata = key_s_high_reg;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_r_low_reg  <= '0;
            key_r_high_reg <= '0;
            key_s_low_reg  <= '0;
            key_s_high_reg <= '0;
        end
        else
        begin
            key_r_low_reg  <= key_r_low_next;
            key_r_high_reg <= key_r_high_next;
            key_s_low_reg  <= key_s_low_next;
            key_s_high_reg <= key_s_high_next;
        end
    end

    p1305_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .block_low  (block_low),
        .block_high (block_high),
        .block_len  (block_len),
        .last_block (last_block),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    p1305_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    p1305_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .key_r     ({key_r_high_reg, key_r_low_reg}),
        .key_s     ({key_s_high_reg, key_s_low_reg}),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tag_low   (tag_low),
        .tag_high  (tag_high)
    );

endmodule

### bench/poly1305_tag_checker.sv
`timescale 1ns / 1ps

module poly1305_tag_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic [63:0] prdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    input  logic [4:0]  block_len,
    input  logic        last_block,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] tag_low,
    input  logic [63:0] tag_high,
    output int          failures,
    output int          tags_pending
);

    localparam logic [129:0] PRIME    = {130{1'b1}} - 130'd4;
    localparam logic [127:0] R_CLAMP  = 128'h0ffffffc0ffffffc0ffffffc0fffffff;
    localparam logic [259:0] LOW_MASK = {130'd0, {130{1'b1}}};

    logic [63:0]  key_regs [4];
    logic [129:0] acc;
    logic [127:0] tags_due [$];
    logic [127:0] exp_tag;
    int           fail_cnt;

    // keep the valid bytes, then append the 0x01 marker byte right after them
    function automatic logic [128:0] pad_block(logic [63:0] lo, logic [63:0] hi,
                                               logic [4:0] len);
        logic [128:0] m;
        int           nbytes;
        nbytes = (len > 5'd16) ? 16 : int'(len);
        m = {1'b0, hi, lo} & ((129'd1 << (8 * nbytes)) - 129'd1);
        return m | (129'd1 << (8 * nbytes));
    endfunction

    // (acc + m) * r mod 2^130-5, fully reduced
    function automatic logic [129:0] absorb_block(logic [129:0] acc_in, logic [128:0] m,
                                                  logic [127:0] r);
        logic [259:0] x;
        logic [259:0] rr;
        x  = {130'd0, acc_in};
        x  = x + {131'd0, m};
        rr = {132'd0, r};
        x  = x * rr;
        // 2^130 is congruent to 5
        repeat (2) x = (x & LOW_MASK) + (x >> 130) * 260'd5;
        while (x >= {130'd0, PRIME}) x = x - {130'd0, PRIME};
        return x[129:0];
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) key_regs[i] = '0;
            acc = '0;
            tags_due.delete();
            fail_cnt = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                    key_regs[paddr[4:3]] = pwdata;
                else if (prdata !== key_regs[paddr[4:3]])
                begin
                    $error("prdata: expected %h, got %h", key_regs[paddr[4:3]], prdata);
                    fail_cnt++;
                end
            end

            if (in_valid && in_ready)
            begin
                if (block_len != 5'd0)
                    acc = absorb_block(acc,
                                       pad_block(block_low, block_high, block_len),
                                       {key_regs[p1305_pkg::REG_KEY_R_HIGH],
                                        key_regs[p1305_pkg::REG_KEY_R_LOW]} & R_CLAMP);
                if (last_block)
                begin
                    tags_due.push_back(acc[127:0]
                                       + {key_regs[p1305_pkg::REG_KEY_S_HIGH],
                                          key_regs[p1305_pkg::REG_KEY_S_LOW]});
                    acc = '0;
                end
            end

            if (out_valid && out_ready)
            begin
                if (tags_due.size() == 0)
                begin
                    $error("tag %h_%h with no message finished", tag_high, tag_low);
                    fail_cnt++;
                end
                else
                begin
                    exp_tag = tags_due.pop_front();
                    if (tag_low !== exp_tag[63:0])
                    begin
                        $error("tag_low: expected %h, got %h", exp_tag[63:0], tag_low);
                        fail_cnt++;
                    end
                    if (tag_high !== exp_tag[127:64])
                    begin
                        $error("tag_high: expected %h, got %h", exp_tag[127:64], tag_high);
                        fail_cnt++;
                    end
                end
            end
        end
        failures     <= fail_cnt;
        tags_pending <= tags_due.size();
    end

endmodule

### bench/poly1305_mac_accumulator_tb.sv
`timescale 1ns / 1ps

module poly1305_mac_accumulator_tb;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int SETTLE_CYCLES   = 150;
    localparam int CYCLE_LIMIT     = 600000;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [4:0]  paddr      = '0;
    logic [63:0] pwdata     = '0;
    logic        in_valid   = 1'b0;
    logic [63:0] block_low  = '0;
    logic [63:0] block_high = '0;
    logic [4:0]  block_len  = '0;
    logic        last_block = 1'b0;
    logic        out_ready  = 1'b0;

    logic [63:0] prdata;
    logic        pready;
    logic        in_ready;
    logic        out_valid;
    logic [63:0] tag_low;
    logic [63:0] tag_high;

    int failures;
    int tags_pending;
    int cycle_cnt = 0;
    int rx_wait   = 0;
    int rx_draw;
    int sent;
    bit tx_quiet  = 1'b0;
    bit rx_quiet  = 1'b0;

    always #5 clk = ~clk;

    poly1305_mac_accumulator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .block_low  (block_low),
        .block_high (block_high),
        .block_len  (block_len),
        .last_block (last_block),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tag_low    (tag_low),
        .tag_high   (tag_high)
    );

    poly1305_tag_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .block_low    (block_low),
        .block_high   (block_high),
        .block_len    (block_len),
        .last_block   (last_block),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tag_low      (tag_low),
        .tag_high     (tag_high),
        .failures     (failures),
        .tags_pending (tags_pending)
    );

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int gap_draw(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 12));
    endfunction

    // tag receiver: stall a random number of cycles after each transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else if (out_ready)
        begin
            if (out_valid)
            begin
                if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
                rx_draw = gap_draw(rx_quiet);
                rx_wait   <= rx_draw;
                out_ready <= (rx_draw == 0);
            end
        end
        else if (rx_wait > 1)
        begin
            rx_wait <= rx_wait - 1;
        end
        else
        begin
            rx_wait   <= 0;
            out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input p1305_pkg::reg_idx_t idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic read_reg(input p1305_pkg::reg_idx_t idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic load_keys(input logic [63:0] r_lo, input logic [63:0] r_hi,
                             input logic [63:0] s_lo, input logic [63:0] s_hi);
        write_reg(p1305_pkg::REG_KEY_R_LOW, r_lo);
        write_reg(p1305_pkg::REG_KEY_R_HIGH, r_hi);
        write_reg(p1305_pkg::REG_KEY_S_LOW, s_lo);
        write_reg(p1305_pkg::REG_KEY_S_HIGH, s_hi);
        read_reg(p1305_pkg::REG_KEY_R_LOW);
        read_reg(p1305_pkg::REG_KEY_R_HIGH);
        read_reg(p1305_pkg::REG_KEY_S_LOW);
        read_reg(p1305_pkg::REG_KEY_S_HIGH);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input logic lst);
        int gap;
        if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
        gap = gap_draw(tx_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        block_low  <= lo;
        block_high <= hi;
        block_len  <= len;
        last_block <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (len != 5'd0 || lst) sent++;
    endtask

    // stop sending, let every tag arrive, then let blocks without a tag finish too
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tags_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] msg_word();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_message();
        int         nfull;
        logic [4:0] len;
        logic       lst;
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: any length code, any end flag
            len = 5'($urandom_range(0, 31));
            lst = 1'($urandom_range(0, 1));
            send_block({$urandom, $urandom}, {$urandom, $urandom}, len, lst);
        end
        else
        begin
            nfull = ($urandom_range(0, 15) == 0) ? int'($urandom_range(7, 20))
                                                 : int'($urandom_range(0, 4));
            repeat (nfull) send_block(msg_word(), msg_word(), 5'd16, 1'b0);
            len = 5'($urandom_range(1, 16));
            send_block(msg_word(), msg_word(), len, 1'b1);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // largest clamped r and s
        load_keys('1, '1, '1, '1);
        send_block('0, '0, 5'd0, 1'b1);
        send_block('1, '1, 5'd16, 1'b0);
        send_block('1, '1, 5'd16, 1'b1);
        send_block('0, '0, 5'd16, 1'b1);
        send_block('1, '1, 5'd1, 1'b0);
        send_block('1, '1, 5'd7, 1'b0);
        send_block('1, '1, 5'd8, 1'b0);
        send_block('1, '1, 5'd9, 1'b0);
        send_block('1, '1, 5'd15, 1'b1);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd0, 1'b0);
        send_block('1, '1, 5'd17, 1'b0);
        send_block('1, '1, 5'd31, 1'b1);
        // garbage past the length must not leak in
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd3, 1'b1);
        send_block('0, '1, 5'd8, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0:       load_keys('0, '0, '0, '0);
                1:       load_keys('1, '1, '0, '0);
                2:       load_keys('0, '0, '1, '1);
                default: load_keys({$urandom, $urandom}, {$urandom, $urandom},
                                   {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) send_message();
        end

        drain();
        if (failures == 0 && tags_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
